// ----- rtl/qeld_pkg.sv -----
// Package for the quadrangle edge line distance block.
// Widths, register indexes and payload types. No dependencies.
package qeld_pkg;

	// coordinate and internal widths
	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;          // P-A, B-A and the like
	localparam int PROD_BITS  = 2 * DIFF_BITS;           // cross product, squared length
	localparam int SQ_BITS    = 2 * PROD_BITS;           // cross product squared
	localparam int REM_BITS   = 4 * COORD_BITS + 8;      // signed root remainder
	localparam int UACC_BITS  = 3 * COORD_BITS + 6;      // signed running s*L term
	localparam int DIST_BITS  = COORD_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_A_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_A_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_X = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_Y = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_Y = 3'd5;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
	} query_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] dist_to_ab;
		logic [DIST_BITS-1:0] dist_to_bc;
		logic                 degenerate;
	} result_t;

	// offset of P from a line's first point and the line's direction
	typedef struct packed {
		logic signed [DIFF_BITS-1:0] ux;
		logic signed [DIFF_BITS-1:0] uy;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
	} line_geom_t;

	// one classified item between front and back
	typedef struct packed {
		line_geom_t ab;
		line_geom_t bc;
		logic       degenerate;
	} work_t;

endpackage

// ----- rtl/qeld_front.sv -----
// Front end: corner registers, query accept, offsets and degenerate check.
// Depends on qeld_pkg.
module qeld_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 hold,
	input  qeld_pkg::query_t                     query,
	input  logic                                 cfg_valid,
	input  logic [qeld_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [qeld_pkg::COORD_BITS-1:0]      cfg_data,
	output logic                                 work_valid,
	output qeld_pkg::work_t                      work
);
	localparam int N = qeld_pkg::COORD_BITS;
	localparam int D = qeld_pkg::DIFF_BITS;

	logic [N-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic         valid_s1;
	qeld_pkg::work_t work_s1, work_d;
	logic         accept;

	// corner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0;
			bx_q <= '0; by_q <= '0;
			cx_q <= '0; cy_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qeld_pkg::REG_A_X: ax_q <= cfg_data;
				qeld_pkg::REG_A_Y: ay_q <= cfg_data;
				qeld_pkg::REG_B_X: bx_q <= cfg_data;
				qeld_pkg::REG_B_Y: by_q <= cfg_data;
				qeld_pkg::REG_C_X: cx_q <= cfg_data;
				qeld_pkg::REG_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [D-1:0] sdiff(input logic [N-1:0] a, input logic [N-1:0] b);
		sdiff = $signed({a[N-1], a}) - $signed({b[N-1], b});
	endfunction

	assign accept = start && !hold;

	// offsets and directions of both lines
	always_comb begin
		work_d.ab.ux = sdiff(query.query_x, ax_q);
		work_d.ab.uy = sdiff(query.query_y, ay_q);
		work_d.ab.dx = sdiff(bx_q, ax_q);
		work_d.ab.dy = sdiff(by_q, ay_q);
		work_d.bc.ux = sdiff(query.query_x, bx_q);
		work_d.bc.uy = sdiff(query.query_y, by_q);
		work_d.bc.dx = sdiff(cx_q, bx_q);
		work_d.bc.dy = sdiff(cy_q, by_q);
		work_d.degenerate = ((ax_q == bx_q) && (ay_q == by_q)) ||
		                    ((bx_q == cx_q) && (by_q == cy_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work_d;
		end
	end

	assign work_valid = valid_s1;
	assign work       = work_s1;
endmodule

// ----- rtl/qeld_queue.sv -----
// Short queue between front and back; drains one beat per cycle.
// Depends on qeld_pkg.
module qeld_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qeld_pkg::work_t push_data,
	output logic            nearly_full,
	output logic            out_valid,
	output qeld_pkg::work_t out_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qeld_pkg::work_t mem [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic          out_valid_q;
	qeld_pkg::work_t out_data_q;

	assign pop = (count_q != '0);
	// a held beat always pops, so the count never grows past one; hold only when full
	assign nearly_full = (count_q >= CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			out_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= pop;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

// ----- rtl/qeld_lane.sv -----
// Distance of P to one line: cross product, squaring, then a one bit per
// stage rounded root of c^2/L. Depends on qeld_pkg.
module qeld_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  qeld_pkg::line_geom_t                geom,
	input  logic                                zero_in,
	output logic                                out_valid,
	output logic                                zero_out,
	output logic [qeld_pkg::DIST_BITS-1:0]      distance
);
	localparam int N  = qeld_pkg::COORD_BITS;
	localparam int D  = qeld_pkg::DIFF_BITS;
	localparam int P  = qeld_pkg::PROD_BITS;
	localparam int SQ = qeld_pkg::SQ_BITS;
	localparam int R  = qeld_pkg::REM_BITS;
	localparam int UA = qeld_pkg::UACC_BITS;
	localparam int DB = qeld_pkg::DIST_BITS;

	function automatic logic [D-1:0] mag(input logic [D-1:0] v);
		mag = v[D-1] ? (~v + 1'b1) : v;
	endfunction

	// stage 1: magnitudes and 33x33 products
	logic         v_s1, z_s1, diff_s1;
	logic [P-1:0] p1_s1, p2_s1, lx_s1, ly_s1;
	logic [D-1:0] mux, muy, mdx, mdy;

	always_comb begin
		mux = mag(geom.ux);
		muy = mag(geom.uy);
		mdx = mag(geom.dx);
		mdy = mag(geom.dy);
	end

	always_ff @(posedge clk) begin
		p1_s1   <= mux * mdy;
		p2_s1   <= muy * mdx;
		lx_s1   <= mdx * mdx;
		ly_s1   <= mdy * mdy;
		diff_s1 <= geom.ux[D-1] ^ geom.dy[D-1] ^ geom.uy[D-1] ^ geom.dx[D-1];
		z_s1    <= zero_in;
	end

	// stage 2: |cross| and squared length
	logic         v_s2, z_s2;
	logic [P-1:0] c_s2, l_s2;

	always_ff @(posedge clk) begin
		if (diff_s1) begin
			c_s2 <= p1_s1 + p2_s1;
		end else if (p1_s1 >= p2_s1) begin
			c_s2 <= p1_s1 - p2_s1;
		end else begin
			c_s2 <= p2_s1 - p1_s1;
		end
		l_s2 <= lx_s1 + ly_s1;
		z_s2 <= z_s1;
	end

	// stage 3: partial products of c^2
	logic         v_s3, z_s3;
	logic [P-1:0] hh_s3, hl_s3, ll_s3, l_s3;
	logic [D-1:0] ch, cl;

	assign ch = c_s2[P-1:D];
	assign cl = c_s2[D-1:0];

	always_ff @(posedge clk) begin
		hh_s3 <= ch * ch;
		hl_s3 <= ch * cl;
		ll_s3 <= cl * cl;
		l_s3  <= l_s2;
		z_s3  <= z_s2;
	end

	// stage 4: start values of the root recurrence
	logic [SQ-1:0] c2;
	logic signed [R-1:0]  rem0;
	logic signed [UA-1:0] u0;

	always_comb begin
		c2   = (SQ'(hh_s3) << P) + (SQ'(hl_s3) << (D + 1)) + SQ'(ll_s3);
		rem0 = $signed(R'(c2) << 2) - $signed(R'(l_s3));
		u0   = $signed(UA'(l_s3) << N) - $signed(UA'(l_s3));
	end

	// root stages: index 0 holds the start values, stage k decides bit N-k
	logic signed [R-1:0]  rem_s [0:N];
	logic signed [UA-1:0] u_s   [0:N];
	logic [P-1:0]         l_s   [0:N];
	logic [DB-1:0]        r_s   [0:N+1];
	logic                 z_s   [0:N+1];
	logic                 v_s   [0:N+1];

	always_ff @(posedge clk) begin
		rem_s[0] <= rem0;
		u_s[0]   <= u0;
		l_s[0]   <= l_s3;
		r_s[0]   <= '0;
		z_s[0]   <= z_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s[0] <= v_s3;
		end
	end

	for (genvar k = 0; k <= N; k++) begin : g_step
		localparam int B = N - k;
		logic signed [R-1:0] trial;
		logic                take;

		// remainder 4c^2 - s^2 L after trying to set bit B
		always_comb begin
			trial = rem_s[k] - ($signed(R'(u_s[k])) <<< (B + 2));
			take  = !trial[R-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			r_s[k+1] <= take ? (r_s[k] | (DB'(1) << B)) : r_s[k];
			z_s[k+1] <= z_s[k];
		end

		if (B > 0) begin : g_upd
			logic signed [UA-1:0] lb, lb1;
			always_comb begin
				lb  = $signed(UA'(l_s[k]) << B);
				lb1 = $signed(UA'(l_s[k]) << (B - 1));
			end
			// s*L + 2^(B-1) L for the next bit
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? trial : rem_s[k];
				u_s[k+1]   <= take ? (u_s[k] + lb + lb1) : (u_s[k] - lb1);
				l_s[k+1]   <= l_s[k];
			end
		end
	end

	assign out_valid = v_s[N+1];
	assign zero_out  = z_s[N+1];
	assign distance  = z_s[N+1] ? '0 : r_s[N+1];
endmodule

// ----- rtl/qeld_back.sv -----
// Back end: the two line lanes and the result register.
// Depends on qeld_pkg and qeld_lane.
module qeld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qeld_pkg::work_t   work,
	output logic              done,
	output qeld_pkg::result_t result
);
	logic ab_valid, bc_valid, ab_zero, bc_zero;
	logic [qeld_pkg::DIST_BITS-1:0] ab_dist, bc_dist;
	logic done_q;
	qeld_pkg::result_t result_q;

	qeld_lane u_lane_ab (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.geom     (work.ab),
		.zero_in  (work.degenerate),
		.out_valid(ab_valid),
		.zero_out (ab_zero),
		.distance (ab_dist)
	);

	qeld_lane u_lane_bc (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.geom     (work.bc),
		.zero_in  (work.degenerate),
		.out_valid(bc_valid),
		.zero_out (bc_zero),
		.distance (bc_dist)
	);

	// both lanes run in lockstep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ab_valid && bc_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.dist_to_ab <= ab_dist;
		result_q.dist_to_bc <= bc_dist;
		result_q.degenerate <= ab_zero | bc_zero;
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

// ----- rtl/quad_edge_line_distances.sv -----
// Top level: distances from a query point to lines AB and BC.
// Depends on qeld_pkg, qeld_front, qeld_queue, qeld_back.
//
//  channel  handshake              beat
//  query    start / busy           query_t (query_x, query_y)
//  result   done strobe            result_t (dist_to_ab, dist_to_bc, degenerate)
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One query is taken per cycle; busy only rises if the queue backs up.
// A result strobes done after its query beat passes the front register,
// queue write and registered read, four product stages, 33 root stages
// (one result bit each) and the output register.
// Reset clears the corners to zero and empties all stages.
// The receiver cannot stall; results leave on done unconditionally.
module quad_edge_line_distances #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  qeld_pkg::query_t                  query,
	output logic                              done,
	output qeld_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qeld_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [qeld_pkg::COORD_BITS-1:0]   cfg_data
);
	logic            front_valid, queue_full, queue_valid;
	qeld_pkg::work_t front_work, queue_work;

	assign cfg_ready = 1'b1;
	assign busy      = queue_full;

	qeld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.hold      (queue_full),
		.query     (query),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.work_valid(front_valid),
		.work      (front_work)
	);

	qeld_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_data  (front_work),
		.nearly_full(queue_full),
		.out_valid  (queue_valid),
		.out_data   (queue_work)
	);

	qeld_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(queue_valid),
		.work    (queue_work),
		.done    (done),
		.result  (result)
	);
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for quad_edge_line_distances: directed table, then random phases of corners and queries.
// Results are checked against an exact big-integer distance calculator. Depends on qeld_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY_WAIT = 48;
	localparam int CYCLE_LIMIT  = 600000;
	localparam logic [qeld_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [qeld_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [31:0] MAX_C = 32'h7fff_ffff;
	localparam logic [31:0] MIN_C = 32'h8000_0000;
	localparam logic [31:0] ONE_C = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	qeld_pkg::query_t query = '0;
	logic done;
	qeld_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [qeld_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [qeld_pkg::COORD_BITS-1:0] cfg_data = '0;

	// shadow copy of the corner registers: ax, ay, bx, by, cx, cy
	logic [31:0] corner [0:5];
	qeld_pkg::result_t pending_results [$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_enabled = 1'b1;

	quad_edge_line_distances u_dut (.*);

	always #6 clk = ~clk;

	// round(|cross(u, d)| / |d|) by a bitwise root search on exact integers
	function automatic logic [32:0] line_distance(logic signed [33:0] ux, logic signed [33:0] uy,
			logic signed [33:0] dx, logic signed [33:0] dy);
		logic signed [79:0] cr;
		logic [199:0] cmag, c4, len_sq, t, q;
		logic [32:0] r;
		logic [32:0] cand;
		cr = 80'(ux) * 80'(dy) - 80'(uy) * 80'(dx);
		cmag = (cr < 0) ? 200'(-cr) : 200'(cr);
		c4 = 4 * cmag * cmag;
		len_sq = 200'(80'(dx) * 80'(dx)) + 200'(80'(dy) * 80'(dy));
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			cand = r | (33'd1 << b);
			t = 2 * 200'(cand) - 1;
			q = t * t * len_sq;
			if (q <= c4)
				r = cand;
		end
		return r;
	endfunction

	function automatic qeld_pkg::result_t predict_distances(logic [31:0] px, logic [31:0] py);
		qeld_pkg::result_t res;
		logic signed [33:0] ax, ay, bx, by, cx, cy, sx, sy;
		ax = 34'(signed'(corner[0])); ay = 34'(signed'(corner[1]));
		bx = 34'(signed'(corner[2])); by = 34'(signed'(corner[3]));
		cx = 34'(signed'(corner[4])); cy = 34'(signed'(corner[5]));
		sx = 34'(signed'(px)); sy = 34'(signed'(py));
		res = '0;
		if ((ax == bx && ay == by) || (bx == cx && by == cy)) begin
			res.degenerate = 1'b1;
		end else begin
			res.dist_to_ab = line_distance(sx - ax, sy - ay, bx - ax, by - ay);
			res.dist_to_bc = line_distance(sx - bx, sy - by, cx - bx, cy - by);
		end
		return res;
	endfunction

	// reset and cycle limit
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		qeld_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", result);
			end else begin
				want = pending_results.pop_front();
				if (result.dist_to_ab !== want.dist_to_ab || result.dist_to_bc !== want.dist_to_bc
						|| result.degenerate !== want.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ab=%h bc=%h deg=%b got ab=%h bc=%h deg=%b",
							want.dist_to_ab, want.dist_to_bc, want.degenerate,
							result.dist_to_ab, result.dist_to_bc, result.degenerate);
				end
			end
		end
	end

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// send one query beat; expectation is queued when the beat is taken
	task automatic send_query(logic [31:0] qx, logic [31:0] qy, bit typed,
			qeld_pkg::result_t typed_res);
		@(negedge clk);
		start = 1'b1;
		query.query_x = qx;
		query.query_y = qy;
		do @(posedge clk); while (busy);
		if (typed) pending_results.push_back(typed_res);
		else pending_results.push_back(predict_distances(qx, qy));
	endtask

	task automatic drain;
		idle_cycles(1);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [qeld_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_SPARE_LO) corner[idx] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_corners(logic [31:0] v [0:5]);
		write_reg(qeld_pkg::REG_A_X, v[0]);
		write_reg(qeld_pkg::REG_A_Y, v[1]);
		write_reg(qeld_pkg::REG_B_X, v[2]);
		write_reg(qeld_pkg::REG_B_Y, v[3]);
		write_reg(qeld_pkg::REG_C_X, v[4]);
		write_reg(qeld_pkg::REG_C_Y, v[5]);
		// spare indexes must leave the corners alone
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 3) == 0 ? MAX_C : MIN_C;
			2: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
			3: return 32'(signed'($urandom_range(0, 200000)) - 100000);
			default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	typedef struct {
		int setup;
		logic [31:0] qx, qy;
		bit typed;
		qeld_pkg::result_t res;
	} stim_row_t;

	initial begin
		stim_row_t rows [$];
		logic [31:0] setups [0:3][0:5];
		logic [31:0] v [0:5];
		int cur_setup;
		int sent;
		for (int i = 0; i < 6; i++) corner[i] = '0;
		// corner sets: all zero, unit square, extreme diagonal, tilted AB edge of Pythagorean-triple length
		setups[0] = '{0, 0, 0, 0, 0, 0};
		setups[1] = '{0, 0, ONE_C, 0, ONE_C, ONE_C};
		setups[2] = '{MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C};
		setups[3] = '{0, 0, 3, 4, 3, 4 + ONE_C};
		rows = '{
			'{0, 0, 0, 1, '{0, 0, 1}},
			'{0, MAX_C, MIN_C, 1, '{0, 0, 1}},
			'{0, MIN_C, MAX_C, 1, '{0, 0, 1}},
			'{1, 0, 0, 1, '{0, ONE_C, 0}},
			'{1, 0, 3 * ONE_C, 1, '{3 * ONE_C, ONE_C, 0}},
			'{1, MAX_C, MIN_C, 1, '{33'h0_8000_0000, 33'h0_7ffe_ffff, 0}},
			'{1, MIN_C, MAX_C, 1, '{33'h0_7fff_ffff, 33'h0_8001_0000, 0}},
			'{1, MIN_C, MIN_C, 0, '{0, 0, 0}},
			'{2, MAX_C, MIN_C, 0, '{0, 0, 0}},
			'{2, MIN_C, MAX_C, 0, '{0, 0, 0}},
			'{2, 0, 0, 0, '{0, 0, 0}},
			'{2, MAX_C, MAX_C, 0, '{0, 0, 0}},
			'{3, 1, 2, 0, '{0, 0, 0}},
			'{3, 32'hffff_ffff, 7, 0, '{0, 0, 0}},
			'{3, MAX_C, MAX_C, 0, '{0, 0, 0}},
			'{3, MIN_C, 1, 0, '{0, 0, 0}}
		};

		wait (arst_n);
		cur_setup = 0;
		foreach (rows[i]) begin
			if (rows[i].setup != cur_setup) begin
				drain();
				cur_setup = rows[i].setup;
				set_corners(setups[cur_setup]);
			end
			send_query(rows[i].qx, rows[i].qy, rows[i].typed, '0 | rows[i].res);
		end

		// random phases: new corners, then a burst of queries
		sent = 0;
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			for (int i = 0; i < 6; i++) v[i] = rand_coord();
			if (ph % 4 == 1) begin
				v[2] = v[0]; v[3] = v[1];          // zero-length AB
			end else if (ph % 4 == 2) begin
				v[4] = v[2]; v[5] = v[3];          // zero-length BC
			end
			if (ph == 8) idle_enabled = 1'b0;    // last stretch at full rate
			set_corners(v);
			repeat (200) begin
				if (idle_enabled && $urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(1, 14));
				send_query(rand_coord(), rand_coord(), 1'b0, '0);
				sent++;
			end
		end

		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
